### design/nsfs_pkg.sv
// Shared constants and controller/datapath interface types for next_smooth_fft_size.
package nsfs_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int LIMIT_BITS = 16;
  localparam logic [LIMIT_BITS-1:0] PRIME_LIMIT_RESET = 16'd7;

  typedef struct packed {
    logic load_req;   // take a new request into candidate and remainder
    logic restart;    // candidate rejected: try the next one
    logic shift2;     // strip one factor of two
    logic init_odd;   // divisor = 3, square = 9
    logic div_start;  // load the divider from the remainder
    logic div_again;  // remainder = quotient, divide by the same divisor again
    logic div_step;   // one restoring division step
    logic next_odd;   // divisor += 2, square updated
    logic emit;       // load the output register with the candidate
  } nsfs_cmd_t;

  typedef struct packed {
    logic even;       // remainder above one and even
    logic sq_gt_n;    // divisor squared exceeds remainder
    logic d_gt_lim;   // divisor above the limit
    logic n_le_lim;   // remainder within the limit
    logic div_last;   // final division step this cycle
    logic rem_zero;   // divisor divides the remainder
    logic out_free;   // output register can take a result
  } nsfs_sts_t;

endpackage

### design/nsfs_ctrl.sv
// Sequencer for the candidate search and trial division.
module nsfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nsfs_pkg::nsfs_sts_t sts,
  output nsfs_pkg::nsfs_cmd_t cmd
);
  import nsfs_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_STRIP   = 3'd1;
  localparam logic [2:0] ST_CHECK   = 3'd2;
  localparam logic [2:0] ST_DIV     = 3'd3;
  localparam logic [2:0] ST_DIVDONE = 3'd4;
  localparam logic [2:0] ST_FINISH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (sts.even) begin
          cmd.shift2 = 1'b1;
        end else begin
          cmd.init_odd = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.sq_gt_n) begin
          if (sts.n_le_lim) begin
            state_next = ST_FINISH;
          end else begin
            cmd.restart = 1'b1;
            state_next  = ST_STRIP;
          end
        end else if (sts.d_gt_lim) begin
          // leftover has only factors at or above the divisor
          cmd.restart = 1'b1;
          state_next  = ST_STRIP;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DIVDONE;
        end
      end
      ST_DIVDONE: begin
        if (sts.rem_zero) begin
          cmd.div_again = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.next_odd = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/nsfs_dp.sv
// Datapath: candidate, remainder, odd divisor and its square, serial divider, result register.
module nsfs_dp #(
  parameter int LENGTH_BITS = nsfs_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nsfs_pkg::nsfs_cmd_t             cmd,
  output nsfs_pkg::nsfs_sts_t             sts,
  input  logic [LENGTH_BITS-1:0]          requested_length,
  input  logic [nsfs_pkg::LIMIT_BITS-1:0] prime_limit,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [LENGTH_BITS:0]            chosen_length
);
  import nsfs_pkg::*;

  localparam int NW = LENGTH_BITS + 1;          // candidate and remainder
  localparam int DW = LENGTH_BITS / 2 + 2;      // odd divisor, up to sqrt plus two
  localparam int SW = LENGTH_BITS + 2;          // divisor squared
  localparam int CW = (NW > LIMIT_BITS) ? NW : LIMIT_BITS;
  localparam int KW = $clog2(NW);
  localparam logic [KW-1:0] STEP_LAST = KW'(NW - 1);

  logic [NW-1:0] cand;
  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic [SW-1:0] sq;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [KW-1:0] step;

  logic [LIMIT_BITS-1:0] lim_eff;
  logic [NW-1:0]         req_eff;
  logic [NW-1:0]         cand_inc;
  logic [DW:0]           rem_sh;
  logic                  fits;

  assign lim_eff  = (prime_limit < LIMIT_BITS'(2)) ? LIMIT_BITS'(2) : prime_limit;
  assign req_eff  = (requested_length == '0) ? NW'(1) : NW'(requested_length);
  assign cand_inc = cand + NW'(1);
  assign rem_sh   = {rem, quo[NW-1]};
  assign fits     = (rem_sh >= (DW+1)'(d));

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cand <= req_eff;
      n    <= req_eff;
    end else if (cmd.restart) begin
      cand <= cand_inc;
      n    <= cand_inc;
    end else if (cmd.shift2) begin
      n <= n >> 1;
    end else if (cmd.div_again) begin
      n <= quo;
    end

    if (cmd.init_odd) begin
      d  <= DW'(3);
      sq <= SW'(9);
    end else if (cmd.next_odd) begin
      // (d+2)^2 = d^2 + 4d + 4
      d  <= d + DW'(2);
      sq <= sq + SW'({d, 2'b00}) + SW'(4);
    end

    if (cmd.div_start) begin
      quo  <= n;
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_again) begin
      quo  <= quo;
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[NW-2:0], fits};
      rem  <= fits ? DW'(rem_sh - (DW+1)'(d)) : rem_sh[DW-1:0];
      step <= step + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      chosen_length <= cand;
    end
  end

  assign sts.even     = (n > NW'(1)) && !n[0];
  assign sts.sq_gt_n  = (sq > SW'(n));
  assign sts.d_gt_lim = (CW'(d) > CW'(lim_eff));
  assign sts.n_le_lim = (CW'(n) <= CW'(lim_eff));
  assign sts.div_last = (step == STEP_LAST);
  assign sts.rem_zero = (rem == '0);
  assign sts.out_free = !out_valid || out_ready;

endmodule

### design/next_smooth_fft_size.sv
// Top level of next_smooth_fft_size: ports, limit register, controller and datapath.
//
// Use: a request on the s_ channel carries a transform length; the block answers on the
// m_ channel with the smallest length at least that large whose prime factors are all
// at most prime_limit (zero is taken as one, a limit below two as two).
// prime_limit is written over the cfg_ channel (cfg_ready is always high); the user
// must write it only while the block is idle, as the block does not enforce this.
// After reset it holds 7. One request is worked on at a time: s_tready is high only
// while the sequencer is idle. Each candidate first has its factors of two stripped one
// at a time and the divisor set up, then for each odd divisor tried a check and
// divisions by it, repeated while it divides the remainder (the LENGTH_BITS+1 quotient
// bits one a cycle, then a look at the remainder), and a last check; a rejected
// candidate starts over with the next length from a check. The finish state then
// loads the result. A request of 0 or 1 passes only through the strip, check and
// finish states.
// The result sits in an output register; s_tready returns as the result is loaded, so
// a new request is taken while the previous result still waits. If the
// receiver stalls, the next result waits in the sequencer until the register frees.
// Reset (rst, synchronous) drops any request in progress and any waiting result.
module next_smooth_fft_size #(
  parameter int LENGTH_BITS = nsfs_pkg::LENGTH_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((LENGTH_BITS+7)/8)*8-1:0]        s_tdata,  // requested_length
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((LENGTH_BITS+8)/8)*8-1:0]        m_tdata,  // chosen_length
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [nsfs_pkg::LIMIT_BITS-1:0]         cfg_data  // prime_limit
);
  import nsfs_pkg::*;

  localparam int NW  = LENGTH_BITS + 1;
  localparam int OTW = ((LENGTH_BITS + 8) / 8) * 8;

  logic [LIMIT_BITS-1:0] prime_limit;
  logic [NW-1:0]         chosen_length;
  nsfs_cmd_t             cmd;
  nsfs_sts_t             sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_limit <= PRIME_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prime_limit <= cfg_data;
    end
  end

  nsfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nsfs_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .requested_length (s_tdata[LENGTH_BITS-1:0]),
    .prime_limit      (prime_limit),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .chosen_length    (chosen_length)
  );

  assign m_tdata = OTW'(chosen_length);

  // only one request in flight
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  // a result is never zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chosen_length != '0)
    else $error("zero length delivered");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !cmd.emit)
    else $error("result overwritten while waiting");

endmodule

### verif/tb_next_smooth_fft_size.sv
`timescale 1ns / 1ps
// Testbench for next_smooth_fft_size: directed and random length requests checked against a trial-division predictor.
module tb_next_smooth_fft_size;
  import nsfs_pkg::*;

  localparam int LEN_W = LENGTH_BITS_DEF;
  localparam int S_W = ((LEN_W + 7) / 8) * 8;
  localparam int M_W = ((LEN_W + 8) / 8) * 8;
  localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;
  // at or above this limit wide requests stay cheap, as their odd part is always accepted
  localparam int WIDE_LIMIT = 4096;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 50;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_W-1:0]        s_tdata = '0;    // requested_length
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_W-1:0]        m_tdata;         // chosen_length
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LIMIT_BITS-1:0] cfg_data = '0;   // prime_limit

  logic [LIMIT_BITS-1:0] limit_shadow = PRIME_LIMIT_RESET;
  logic [LEN_W:0]        expected_lengths[$];
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    hold_left = 0;
  int                    error_count = 0;

  always #10 clk = ~clk;

  next_smooth_fft_size #(
    .LENGTH_BITS(LEN_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Smallest length >= req whose prime factors all fit the limit.
  function automatic logic [LEN_W:0] smooth_length_from(input logic [LEN_W-1:0] req,
                                                         input logic [LIMIT_BITS-1:0] limit_reg);
    longint unsigned lim;
    longint unsigned cand;
    longint unsigned rest;
    longint unsigned divisor;
    bit              smooth;
    lim = (limit_reg < 2) ? 2 : limit_reg;
    cand = (req == 0) ? 1 : req;
    smooth = 1'b0;
    while (!smooth) begin
      rest = cand;
      while (rest > 1 && rest[0] == 1'b0) rest = rest >> 1;
      smooth = 1'b1;
      divisor = 3;
      while (smooth && divisor * divisor <= rest) begin
        // all remaining factors are at least the divisor, so it being over the limit is final
        if (divisor > lim) begin
          smooth = 1'b0;
        end else begin
          while (rest % divisor == 0) rest = rest / divisor;
          divisor += 2;
        end
      end
      if (smooth && rest > lim) smooth = 1'b0;
      if (!smooth) cand++;
    end
    return cand[LEN_W:0];
  endfunction

  function automatic logic [LEN_W-1:0] random_request(input logic [LIMIT_BITS-1:0] lim);
    logic [LEN_W-1:0] req;
    int               width;
    req = LEN_W'($urandom);
    if (lim >= WIDE_LIMIT && $urandom_range(1) == 1) begin
      req[11:0] = '0;
      return req;
    end
    width = (lim >= WIDE_LIMIT) ? $urandom_range(16, 1) : $urandom_range(10, 1);
    return req & ((LEN_W'(1) << width) - LEN_W'(1));
  endfunction

  // Receiver: random stalls, or a counted hold-off when one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [LEN_W:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lengths.size() == 0) begin
        $error("chosen_length: no request outstanding, got %0d", m_tdata[LEN_W:0]);
        error_count++;
      end else begin
        want = expected_lengths.pop_front();
        if (m_tdata[LEN_W:0] !== want) begin
          $error("chosen_length: expected %0d, got %0d", want, m_tdata[LEN_W:0]);
          error_count++;
        end
      end
    end
  end

  // valid stays high between back-to-back requests; it only drops on an idle cycle
  task automatic send_request(input logic [LEN_W-1:0] len);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= len;
    do @(posedge clk); while (!s_tready);
    expected_lengths.push_back(smooth_length_from(len, limit_shadow));
  endtask

  task automatic wait_all_returned();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_shadow = value;
    @(posedge clk);
  endtask

  task automatic test_reset_limit();
    send_request(0);
    send_request(1);
    send_request(2);
    send_request(3);
    send_request(11);
    send_request(13);
    send_request(97);
    send_request(24'h800000);
    send_request(24'h7FFFFF);
    send_request(24'hFFFFFF);   // rolls over into bit 24 of the result
    wait_all_returned();
  endtask

  // limits of 0 and 1 behave as 2: answers are powers of two
  task automatic test_limit_below_two();
    write_limit(0);
    send_request(0);
    send_request(5);
    send_request(100);
    send_request(24'hFFFFFF);
    wait_all_returned();
    write_limit(1);
    send_request(3);
    send_request(1000);
    wait_all_returned();
  endtask

  task automatic test_limit_max();
    write_limit(LIMIT_MAX);
    send_request(65537);        // prime just above the limit
    send_request(131074);
    send_request(24'hFFFFFD);   // large prime, longest trial division
    send_request(24'hFFFFFF);
    wait_all_returned();
  endtask

  task automatic test_small_limits();
    write_limit(3);
    send_request(5);
    send_request(1000);
    wait_all_returned();
    write_limit(13);
    send_request(17);
    send_request(1001);
    wait_all_returned();
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (8) send_request(LEN_W'($urandom_range(255)));
    // sender holds off until every result is back
    wait_all_returned();
    repeat (3) send_request(LEN_W'($urandom_range(255)));
    wait_all_returned();
  endtask

  task automatic test_random_traffic();
    int setting;
    setting = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        wait_all_returned();
        case (setting % 3)
          0: write_limit(LIMIT_BITS'($urandom_range(65535, WIDE_LIMIT)));
          1: write_limit(LIMIT_BITS'($urandom_range(15, 0)));
          default: write_limit(LIMIT_BITS'($urandom_range(65535, 0)));
        endcase
        setting++;
        repeat (7) send_request(random_request(limit_shadow));
      end
    end
    wait_all_returned();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_limit();
    test_limit_below_two();
    test_limit_max();
    test_small_limits();
    test_backpressure();
    test_random_traffic();
    wait_all_returned();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_lengths.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(200_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
design/nsfs_pkg.sv
design/nsfs_ctrl.sv
design/nsfs_dp.sv
design/next_smooth_fft_size.sv
verif/tb_next_smooth_fft_size.sv
